### design/dcd_pkg.sv
package dcd_pkg;

    localparam logic [1:0] CMD_LOAD_QUANT = 2'd0;
    localparam logic [1:0] CMD_BYTE       = 2'd1;
    localparam logic [1:0] CMD_REALIGN    = 2'd2;

    localparam logic [1:0] CODE_RUN    = 2'b01;
    localparam logic [1:0] CODE_LEVEL  = 2'b11;
    localparam logic [2:0] CODE_ZERO1  = 3'b000;
    localparam logic [2:0] CODE_ZERO2  = 3'b100;
    localparam logic [2:0] CODE_PLUS   = 3'b010;
    localparam logic [5:0] ESCAPE6     = 6'h3F;
    localparam logic [15:0] DC_BIAS    = 16'd2048;
    localparam logic [5:0] LAST_POS    = 6'd63;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  data_byte;
        logic [5:0]  table_index;
        logic [15:0] table_value;
    } item_t;

    typedef struct packed {
        logic [5:0]         coef_index;
        logic signed [15:0] coef_value;
        logic               block_end;
        logic               fault;
        logic               last_of_run;
    } coef_t;

    typedef enum logic [1:0] {
        DEC_NEED,
        DEC_EMIT,
        DEC_RUN,
        DEC_FAULT
    } dec_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DECODE,
        ST_RUN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic take;
        logic rd_quant;
        logic step;
        logic run_emit;
        logic flush;
    } ctrl_cmd_t;

    typedef struct packed {
        dec_kind_t kind;
        logic      start_decode;
        logic      push_ok;
        logic      out_free;
        logic      pend_valid;
        logic      cnt_zero;
        logic      cnt_one;
    } dp_status_t;

    function automatic logic [5:0] zz_natural(input logic [5:0] pos);
        logic [5:0] r;
        case (pos)
            6'd0:  r = 6'd0;   6'd1:  r = 6'd1;   6'd2:  r = 6'd8;   6'd3:  r = 6'd16;
            6'd4:  r = 6'd9;   6'd5:  r = 6'd2;   6'd6:  r = 6'd3;   6'd7:  r = 6'd10;
            6'd8:  r = 6'd17;  6'd9:  r = 6'd24;  6'd10: r = 6'd32;  6'd11: r = 6'd25;
            6'd12: r = 6'd18;  6'd13: r = 6'd11;  6'd14: r = 6'd4;   6'd15: r = 6'd5;
            6'd16: r = 6'd12;  6'd17: r = 6'd19;  6'd18: r = 6'd26;  6'd19: r = 6'd33;
            6'd20: r = 6'd40;  6'd21: r = 6'd48;  6'd22: r = 6'd41;  6'd23: r = 6'd34;
            6'd24: r = 6'd27;  6'd25: r = 6'd20;  6'd26: r = 6'd13;  6'd27: r = 6'd6;
            6'd28: r = 6'd7;   6'd29: r = 6'd14;  6'd30: r = 6'd21;  6'd31: r = 6'd28;
            6'd32: r = 6'd35;  6'd33: r = 6'd42;  6'd34: r = 6'd49;  6'd35: r = 6'd56;
            6'd36: r = 6'd57;  6'd37: r = 6'd50;  6'd38: r = 6'd43;  6'd39: r = 6'd36;
            6'd40: r = 6'd29;  6'd41: r = 6'd22;  6'd42: r = 6'd15;  6'd43: r = 6'd23;
            6'd44: r = 6'd30;  6'd45: r = 6'd37;  6'd46: r = 6'd44;  6'd47: r = 6'd51;
            6'd48: r = 6'd58;  6'd49: r = 6'd59;  6'd50: r = 6'd52;  6'd51: r = 6'd45;
            6'd52: r = 6'd38;  6'd53: r = 6'd31;  6'd54: r = 6'd39;  6'd55: r = 6'd46;
            6'd56: r = 6'd53;  6'd57: r = 6'd60;  6'd58: r = 6'd61;  6'd59: r = 6'd54;
            6'd60: r = 6'd47;  6'd61: r = 6'd55;  6'd62: r = 6'd62;  6'd63: r = 6'd63;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

endpackage

### design/dcd_item_if.sv
interface dcd_item_if;
    logic           valid;
    logic           ready;
    dcd_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/dcd_coef_if.sv
interface dcd_coef_if;
    logic           valid;
    logic           ready;
    dcd_pkg::coef_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/dct_coefficient_code_decoder.sv
// channel   dir  payload                                              role
// item_ch   in   command, data_byte, table_index, table_value         commands and bytes
// coef_ch   out  coef_index, coef_value, block_end, fault, last_of_run coefficients
//
// A quant load, realign, ignored byte or unused command is handled in the idle state alone.
// A byte is taken in the idle state; each code tried then takes a fetch state (quant memory
// read) and a decode state (decode and multiply), the last try finding an incomplete code or
// a fault; the run state emits each zero of a run (and is passed once for an empty run), and
// the finish state releases its last coefficient.
// Reset clears the bit buffer, scan position and fault; quant entries are undefined.
// A stalled coef_ch holds the decoder in place; item_ch is taken only between bytes.
module dct_coefficient_code_decoder (
    input  logic      clk,
    input  logic      rst_n,
    dcd_item_if.sink  item_ch,
    dcd_coef_if.source coef_ch
);

    dcd_pkg::ctrl_cmd_t  cmd;
    dcd_pkg::dp_status_t status;
    logic                in_ready;
    logic                out_valid;
    dcd_pkg::coef_t      out_data;

    dcd_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dcd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch.data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_ready (coef_ch.ready)
    );

    assign item_ch.ready = in_ready;
    assign coef_ch.valid = out_valid;
    assign coef_ch.data  = out_data;

endmodule

### design/dcd_datapath.sv
module dcd_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dcd_pkg::item_t         item,
    input  dcd_pkg::ctrl_cmd_t     cmd,
    output dcd_pkg::dp_status_t    status,
    output logic                   out_valid,
    output dcd_pkg::coef_t         out_data,
    input  logic                   out_ready
);

    logic [23:0] buf_reg, buf_next;
    logic [4:0]  held_reg, held_next;
    logic [5:0]  scan_reg, scan_next;
    logic        fault_reg, fault_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [15:0] quant_q_reg;
    logic [15:0] quant_mem [64];

    logic           pend_valid_reg, pend_valid_next;
    dcd_pkg::coef_t pend_reg, pend_next;
    logic           out_valid_reg, out_valid_next;
    dcd_pkg::coef_t out_reg, out_next;

    dcd_pkg::dec_kind_t kind;
    logic [4:0]  take_n;
    logic [15:0] level;
    logic [15:0] addend;
    logic [5:0]  run_len;
    logic [6:0]  remain;
    logic [31:0] prod_full;
    logic [15:0] prod;
    logic [4:0]  fill_shift;
    logic        push;
    dcd_pkg::coef_t new_item;
    logic        out_free;

    assign remain = 7'd64 - {1'b0, scan_reg};

    always_comb
    begin
        kind    = dcd_pkg::DEC_NEED;
        take_n  = 5'd0;
        level   = 16'd0;
        addend  = 16'd0;
        run_len = 6'd0;
        if (scan_reg == 6'd0)
        begin
            if (held_reg >= 5'd8)
            begin
                kind   = dcd_pkg::DEC_EMIT;
                take_n = 5'd8;
                level  = {{8{buf_reg[7]}}, buf_reg[7:0]};
                addend = dcd_pkg::DC_BIAS;
            end
        end
        else if (held_reg >= 5'd2)
        begin
            case (buf_reg[1:0])
                dcd_pkg::CODE_RUN:
                begin
                    if (held_reg >= 5'd8)
                    begin
                        if ({1'b0, buf_reg[7:2]} > remain)
                        begin
                            kind = dcd_pkg::DEC_FAULT;
                        end
                        else
                        begin
                            kind    = dcd_pkg::DEC_RUN;
                            take_n  = 5'd8;
                            run_len = buf_reg[7:2];
                        end
                    end
                end
                dcd_pkg::CODE_LEVEL:
                begin
                    if (held_reg >= 5'd8)
                    begin
                        if (buf_reg[7:2] == dcd_pkg::ESCAPE6)
                        begin
                            if (held_reg >= 5'd16)
                            begin
                                kind   = dcd_pkg::DEC_EMIT;
                                take_n = 5'd16;
                                level  = {{8{buf_reg[15]}}, buf_reg[15:8]};
                            end
                        end
                        else
                        begin
                            kind   = dcd_pkg::DEC_EMIT;
                            take_n = 5'd8;
                            level  = {{10{buf_reg[7]}}, buf_reg[7:2]};
                        end
                    end
                end
                default:
                begin
                    if (held_reg >= 5'd3)
                    begin
                        case (buf_reg[2:0])
                            dcd_pkg::CODE_ZERO2:
                            begin
                                if (scan_reg == dcd_pkg::LAST_POS)
                                begin
                                    kind = dcd_pkg::DEC_FAULT;
                                end
                                else
                                begin
                                    kind    = dcd_pkg::DEC_RUN;
                                    take_n  = 5'd3;
                                    run_len = 6'd2;
                                end
                            end
                            dcd_pkg::CODE_ZERO1:
                            begin
                                kind   = dcd_pkg::DEC_EMIT;
                                take_n = 5'd3;
                            end
                            dcd_pkg::CODE_PLUS:
                            begin
                                kind   = dcd_pkg::DEC_EMIT;
                                take_n = 5'd3;
                                level  = 16'd1;
                            end
                            default:
                            begin
                                kind   = dcd_pkg::DEC_EMIT;
                                take_n = 5'd3;
                                level  = 16'hFFFF;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    assign prod_full = level * quant_q_reg;
    assign prod      = prod_full[15:0] + addend;
    assign fill_shift = (held_reg > 5'd16) ? 5'd16 : held_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        buf_next        = buf_reg;
        held_next       = held_reg;
        scan_next       = scan_reg;
        fault_next      = fault_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        push            = 1'b0;
        new_item        = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.take)
        begin
            case (item.command)
                dcd_pkg::CMD_REALIGN:
                begin
                    buf_next   = 24'd0;
                    held_next  = 5'd0;
                    scan_next  = 6'd0;
                    fault_next = 1'b0;
                end
                dcd_pkg::CMD_BYTE:
                begin
                    if (!fault_reg)
                    begin
                        buf_next  = buf_reg | (24'(item.data_byte) << fill_shift);
                        held_next = fill_shift + 5'd8;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.step)
        begin
            case (kind)
                dcd_pkg::DEC_EMIT:
                begin
                    buf_next  = buf_reg >> take_n;
                    held_next = held_reg - take_n;
                    scan_next = scan_reg + 6'd1;
                    push      = 1'b1;
                    new_item.coef_index = dcd_pkg::zz_natural(scan_reg);
                    new_item.coef_value = $signed(prod);
                    new_item.block_end  = (scan_reg == dcd_pkg::LAST_POS);
                end
                dcd_pkg::DEC_RUN:
                begin
                    buf_next  = buf_reg >> take_n;
                    held_next = held_reg - take_n;
                    cnt_next  = run_len;
                end
                dcd_pkg::DEC_FAULT:
                begin
                    fault_next     = 1'b1;
                    push           = 1'b1;
                    new_item.fault = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.run_emit)
        begin
            scan_next = scan_reg + 6'd1;
            cnt_next  = cnt_reg - 6'd1;
            push      = 1'b1;
            new_item.coef_index = dcd_pkg::zz_natural(scan_reg);
            new_item.block_end  = (scan_reg == dcd_pkg::LAST_POS);
        end

        if (push)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = new_item;
            pend_valid_next = 1'b1;
        end

        if (cmd.flush)
        begin
            out_next             = pend_reg;
            out_next.last_of_run = 1'b1;
            out_valid_next       = 1'b1;
            pend_valid_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg        <= 24'd0;
            held_reg       <= 5'd0;
            scan_reg       <= 6'd0;
            fault_reg      <= 1'b0;
            cnt_reg        <= 6'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            buf_reg        <= buf_next;
            held_reg       <= held_next;
            scan_reg       <= scan_next;
            fault_reg      <= fault_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && item.command == dcd_pkg::CMD_LOAD_QUANT)
        begin
            quant_mem[item.table_index] <= item.table_value;
        end
        if (cmd.rd_quant)
        begin
            quant_q_reg <= quant_mem[dcd_pkg::zz_natural(scan_reg)];
        end
    end

    assign status.kind         = kind;
    assign status.start_decode = (item.command == dcd_pkg::CMD_BYTE) && !fault_reg;
    assign status.push_ok      = !pend_valid_reg || out_free;
    assign status.out_free     = out_free;
    assign status.pend_valid   = pend_valid_reg;
    assign status.cnt_zero     = (cnt_reg == 6'd0);
    assign status.cnt_one      = (cnt_reg == 6'd1);

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### design/dcd_controller.sv
module dcd_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  dcd_pkg::dp_status_t    status,
    output dcd_pkg::ctrl_cmd_t     cmd
);

    dcd_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dcd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            dcd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (status.start_decode)
                    begin
                        state_next = dcd_pkg::ST_FETCH;
                    end
                end
            end
            dcd_pkg::ST_FETCH:
            begin
                cmd.rd_quant = 1'b1;
                state_next   = dcd_pkg::ST_DECODE;
            end
            dcd_pkg::ST_DECODE:
            begin
                case (status.kind)
                    dcd_pkg::DEC_EMIT:
                    begin
                        if (status.push_ok)
                        begin
                            cmd.step   = 1'b1;
                            state_next = dcd_pkg::ST_FETCH;
                        end
                    end
                    dcd_pkg::DEC_RUN:
                    begin
                        cmd.step   = 1'b1;
                        state_next = dcd_pkg::ST_RUN;
                    end
                    dcd_pkg::DEC_FAULT:
                    begin
                        if (status.push_ok)
                        begin
                            cmd.step   = 1'b1;
                            state_next = dcd_pkg::ST_FINISH;
                        end
                    end
                    default:
                    begin
                        state_next = dcd_pkg::ST_FINISH;
                    end
                endcase
            end
            dcd_pkg::ST_RUN:
            begin
                if (status.cnt_zero)
                begin
                    state_next = dcd_pkg::ST_FETCH;
                end
                else if (status.push_ok)
                begin
                    cmd.run_emit = 1'b1;
                    if (status.cnt_one)
                    begin
                        state_next = dcd_pkg::ST_FETCH;
                    end
                end
            end
            dcd_pkg::ST_FINISH:
            begin
                if (!status.pend_valid)
                begin
                    state_next = dcd_pkg::ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = dcd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dcd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### design/dcd_checker.sv
module dcd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_ready,
    input dcd_pkg::coef_t out_data
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("coefficient dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("coefficient changed while stalled");

    a_fault_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.fault |-> out_data.last_of_run && !out_data.block_end
            && out_data.coef_value == 16'sd0 && out_data.coef_index == 6'd0)
        else $error("fault item malformed");

    a_block_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.block_end |-> out_data.coef_index == dcd_pkg::LAST_POS
            && !out_data.fault)
        else $error("block end off the last position");

endmodule

bind dct_coefficient_code_decoder dcd_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (coef_ch.valid),
    .out_ready (coef_ch.ready),
    .out_data  (coef_ch.data)
);

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [2:0] CODE_MINUS = 3'b110;
    localparam int RANDOM_ITEMS = 190;

    localparam logic [5:0] ZIGZAG [64] = '{
         0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
        12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
        35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
        58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
    };

    typedef enum {
        FLAW_NONE,
        FLAW_CUT,
        FLAW_ZERO2,
        FLAW_RUN
    } flaw_t;

    bit   clk;
    logic rst_n = 1'b0;

    dcd_item_if item_ch ();
    dcd_coef_if coef_ch ();

    dct_coefficient_code_decoder i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_ch (item_ch),
        .coef_ch (coef_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // decoder state as predicted
    logic [23:0]    bit_pool  = '0;
    int             pool_bits = 0;
    int             scan_pos  = 0;
    bit             halted    = 1'b0;
    logic [15:0]    qmul [64];
    dcd_pkg::coef_t coef_q [$];

    bit pending_bits [$];

    int gap_max    = 0;
    int stall_max  = 0;
    int stall_left = 0;
    int hold_off   = 0;

    int n_items   = 0;
    int n_results = 0;
    int n_blocks  = 0;
    int n_faults  = 0;
    int n_bad     = 0;

    function automatic logic [15:0] pull_bits(input int n);
        logic [15:0] v;
        v = 16'(bit_pool & ((24'd1 << n) - 24'd1));
        bit_pool = bit_pool >> n;
        pool_bits -= n;
        return v;
    endfunction

    function automatic void push_coef(input logic [15:0] value);
        dcd_pkg::coef_t c;
        c.coef_index = ZIGZAG[scan_pos];
        c.coef_value = value;
        c.fault = 1'b0;
        c.last_of_run = 1'b0;
        scan_pos++;
        c.block_end = (scan_pos == 64);
        if (scan_pos == 64)
            scan_pos = 0;
        coef_q.push_back(c);
    endfunction

    function automatic void push_fault();
        dcd_pkg::coef_t c;
        c = '0;
        c.fault = 1'b1;
        halted = 1'b1;
        coef_q.push_back(c);
    endfunction

    function automatic logic [15:0] quant_here();
        return qmul[ZIGZAG[scan_pos]];
    endfunction

    function automatic void decode_pool();
        logic signed [7:0] s8;
        logic signed [5:0] s6;
        int                run;
        while (!halted)
        begin
            if (scan_pos == 0)
            begin
                if (pool_bits < 8)
                    break;
                s8 = 8'(pull_bits(8));
                push_coef(16'(int'(s8) * int'(qmul[0]) + int'(dcd_pkg::DC_BIAS)));
            end
            else if (pool_bits < 2)
                break;
            else if (bit_pool[1:0] == dcd_pkg::CODE_RUN)
            begin
                if (pool_bits < 8)
                    break;
                void'(pull_bits(2));
                run = int'(pull_bits(6));
                if (run > 64 - scan_pos)
                begin
                    push_fault();
                    break;
                end
                repeat (run) push_coef('0);
            end
            else if (bit_pool[1:0] == dcd_pkg::CODE_LEVEL)
            begin
                if (pool_bits < 8)
                    break;
                if (bit_pool[7:2] == dcd_pkg::ESCAPE6)
                begin
                    if (pool_bits < 16)
                        break;
                    void'(pull_bits(8));
                    s8 = 8'(pull_bits(8));
                    push_coef(16'(int'(s8) * int'(quant_here())));
                end
                else
                begin
                    void'(pull_bits(2));
                    s6 = 6'(pull_bits(6));
                    push_coef(16'(int'(s6) * int'(quant_here())));
                end
            end
            else
            begin
                if (pool_bits < 3)
                    break;
                if (bit_pool[2:0] == dcd_pkg::CODE_ZERO2)
                begin
                    if (scan_pos >= 63)
                    begin
                        push_fault();
                        break;
                    end
                    void'(pull_bits(3));
                    push_coef('0);
                    push_coef('0);
                end
                else if (bit_pool[2:0] == dcd_pkg::CODE_ZERO1)
                begin
                    void'(pull_bits(3));
                    push_coef('0);
                end
                else if (bit_pool[2:0] == dcd_pkg::CODE_PLUS)
                begin
                    void'(pull_bits(3));
                    push_coef(quant_here());
                end
                else
                begin
                    void'(pull_bits(3));
                    push_coef(16'(0 - int'(quant_here())));
                end
            end
        end
    endfunction

    // returns 1 when the item has an effect on the block
    function automatic bit predict_item(input dcd_pkg::item_t it);
        int             first;
        dcd_pkg::coef_t c;
        case (it.command)
            dcd_pkg::CMD_LOAD_QUANT:
                qmul[it.table_index] = it.table_value;
            dcd_pkg::CMD_REALIGN:
            begin
                bit_pool = '0;
                pool_bits = 0;
                scan_pos = 0;
                halted = 1'b0;
            end
            dcd_pkg::CMD_BYTE:
            begin
                if (halted)
                    return 1'b0;
                first = coef_q.size();
                if (pool_bits > 16)
                    pool_bits = 16;
                bit_pool = bit_pool | (24'(it.data_byte) << pool_bits);
                pool_bits += 8;
                decode_pool();
                if (coef_q.size() > first)
                begin
                    c = coef_q.pop_back();
                    c.last_of_run = 1'b1;
                    coef_q.push_back(c);
                end
            end
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic send_item(input dcd_pkg::item_t it);
        int gap;
        gap = $urandom_range(0, gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.data = it;
        item_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!item_ch.ready);
        if (predict_item(it))
            n_items++;
    endtask

    task automatic send_fields(input logic [1:0] cmd, input logic [7:0] data_byte,
                               input logic [5:0] idx, input logic [15:0] value);
        dcd_pkg::item_t it;
        it.command = cmd;
        it.data_byte = data_byte;
        it.table_index = idx;
        it.table_value = value;
        send_item(it);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_fields(dcd_pkg::CMD_BYTE, b, 6'($urandom), 16'($urandom));
    endtask

    task automatic send_realign();
        send_fields(dcd_pkg::CMD_REALIGN, 8'($urandom), 6'($urandom), 16'($urandom));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (coef_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic put_bits(input logic [15:0] v, input int n);
        for (int i = 0; i < n; i++)
            pending_bits.push_back(v[i]);
    endtask

    task automatic pump_bytes();
        logic [7:0] b;
        while (pending_bits.size() >= 8)
        begin
            for (int i = 0; i < 8; i++)
                b[i] = pending_bits.pop_front();
            send_byte(b);
        end
    endtask

    // pad to a byte, add noise, realign so the stream starts a fresh block
    task automatic restart_stream(input int noise);
        while (pending_bits.size() % 8 != 0)
            pending_bits.push_back(1'($urandom));
        pump_bytes();
        repeat (noise) send_byte(8'($urandom));
        send_realign();
    endtask

    task automatic code_one(input int room, output int used);
        int         pick;
        logic [5:0] lv;
        pick = $urandom_range(0, 99);
        if (pick < 15 || (pick < 25 && room < 2))
        begin
            put_bits(16'(dcd_pkg::CODE_ZERO1), 3);
            used = 1;
        end
        else if (pick < 25)
        begin
            put_bits(16'(dcd_pkg::CODE_ZERO2), 3);
            used = 2;
        end
        else if (pick < 40)
        begin
            used = ($urandom_range(0, 3) == 0) ? $urandom_range(0, room)
                                               : $urandom_range(0, (room < 6) ? room : 6);
            put_bits(16'(dcd_pkg::CODE_RUN), 2);
            put_bits(16'(used), 6);
        end
        else if (pick < 55)
        begin
            put_bits(16'(dcd_pkg::CODE_PLUS), 3);
            used = 1;
        end
        else if (pick < 65)
        begin
            put_bits(16'(CODE_MINUS), 3);
            used = 1;
        end
        else if (pick < 88)
        begin
            do
                lv = 6'($urandom);
            while (lv == dcd_pkg::ESCAPE6);
            put_bits(16'(dcd_pkg::CODE_LEVEL), 2);
            put_bits(16'(lv), 6);
            used = 1;
        end
        else
        begin
            put_bits(16'(dcd_pkg::CODE_LEVEL), 2);
            put_bits(16'(dcd_pkg::ESCAPE6), 6);
            put_bits(16'($urandom_range(0, 255)), 8);
            used = 1;
        end
    endtask

    task automatic code_block(input flaw_t flaw);
        int pos;
        int stop;
        int used;
        put_bits(16'($urandom_range(0, 255)), 8);
        pos = 1;
        stop = (flaw == FLAW_NONE) ? 64 : $urandom_range(1, 63);
        while (pos < stop)
        begin
            code_one(stop - pos, used);
            pos += used;
            pump_bytes();
        end
        case (flaw)
            FLAW_ZERO2:
            begin
                if (pos < 63)
                begin
                    put_bits(16'(dcd_pkg::CODE_RUN), 2);
                    put_bits(16'(63 - pos), 6);
                end
                put_bits(16'(dcd_pkg::CODE_ZERO2), 3);
            end
            FLAW_RUN:
            begin
                if (pos == 1)
                begin
                    put_bits(16'(dcd_pkg::CODE_ZERO1), 3);
                    pos = 2;
                end
                put_bits(16'(dcd_pkg::CODE_RUN), 2);
                put_bits(16'($urandom_range(65 - pos, 63)), 6);
            end
            default: ;
        endcase
        if (flaw == FLAW_NONE)
            pump_bytes();
        else
            restart_stream($urandom_range(0, 3));
    endtask

    task automatic test_quant_table();
        logic [15:0] value;
        for (int i = 0; i < 64; i++)
        begin
            case (i)
                0:       value = 16'hFFFF;
                1:       value = 16'h0000;
                8:       value = 16'h8000;
                16:      value = 16'h7FFF;
                9:       value = 16'h0001;
                default: value = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 40))
                                                             : 16'($urandom);
            endcase
            send_fields(dcd_pkg::CMD_LOAD_QUANT, 8'($urandom), 6'(i), value);
        end
    endtask

    task automatic test_code_kinds();
        put_bits(16'h80, 8);
        put_bits(16'(dcd_pkg::CODE_ZERO1), 3);
        put_bits(16'(dcd_pkg::CODE_ZERO2), 3);
        put_bits(16'(dcd_pkg::CODE_PLUS), 3);
        put_bits(16'(CODE_MINUS), 3);
        put_bits(16'(dcd_pkg::CODE_LEVEL), 2);
        put_bits(16'h1F, 6);
        put_bits(16'(dcd_pkg::CODE_LEVEL), 2);
        put_bits(16'h20, 6);
        put_bits(16'(dcd_pkg::CODE_LEVEL), 2);
        put_bits(16'(dcd_pkg::ESCAPE6), 6);
        put_bits(16'h7F, 8);
        put_bits(16'(dcd_pkg::CODE_LEVEL), 2);
        put_bits(16'(dcd_pkg::ESCAPE6), 6);
        put_bits(16'h80, 8);
        put_bits(16'(dcd_pkg::CODE_RUN), 2);
        put_bits(16'd0, 6);
        put_bits(16'(dcd_pkg::CODE_LEVEL), 2);
        put_bits(16'h01, 6);
        put_bits(16'(dcd_pkg::CODE_RUN), 2);
        put_bits(16'd53, 6);
        put_bits(16'h7F, 8);
        put_bits(16'(dcd_pkg::CODE_RUN), 2);
        put_bits(16'd63, 6);
        put_bits(16'h00, 8);
        pump_bytes();
        // reload and junk commands mid-block must leave decoding intact
        send_fields(dcd_pkg::CMD_LOAD_QUANT, 8'hFF, 6'd63, 16'h1234);
        send_fields(CMD_UNUSED, 8'hFF, 6'd63, 16'hFFFF);
        put_bits(16'(dcd_pkg::CODE_RUN), 2);
        put_bits(16'd62, 6);
        put_bits(16'(dcd_pkg::CODE_ZERO1), 3);
        restart_stream(0);
    endtask

    task automatic test_faults();
        put_bits(16'h01, 8);
        put_bits(16'(dcd_pkg::CODE_RUN), 2);
        put_bits(16'd62, 6);
        put_bits(16'(dcd_pkg::CODE_ZERO2), 3);
        restart_stream(2);
        put_bits(16'hFE, 8);
        put_bits(16'(dcd_pkg::CODE_ZERO1), 3);
        put_bits(16'(dcd_pkg::CODE_RUN), 2);
        put_bits(16'd63, 6);
        restart_stream(1);
    endtask

    task automatic test_backpressure();
        gap_max = 0;
        stall_max = 0;
        wait_drained();
        hold_off = 300;
        repeat (3) code_block(FLAW_NONE);
        restart_stream(0);
        wait_drained();
    endtask

    task automatic test_random_streams();
        int base;
        int pick;
        base = n_items;
        while (n_items - base < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                gap_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
                stall_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
            end
            pick = $urandom_range(0, 99);
            if (pick < 62)
                code_block(FLAW_NONE);
            else if (pick < 70)
                code_block(FLAW_CUT);
            else if (pick < 76)
                code_block(FLAW_ZERO2);
            else if (pick < 82)
                code_block(FLAW_RUN);
            else if (pick < 88)
                send_fields(dcd_pkg::CMD_LOAD_QUANT, 8'($urandom), 6'($urandom),
                            16'($urandom));
            else if (pick < 93)
            begin
                restart_stream($urandom_range(1, 6));
                restart_stream(0);
            end
            else if (pick < 96)
                send_fields(CMD_UNUSED, 8'($urandom), 6'($urandom), 16'($urandom));
            else
                restart_stream(0);
        end
        restart_stream(0);
    endtask

    initial
    begin
        coef_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                coef_ch.ready = 1'b0;
                hold_off--;
            end
            else if (stall_left > 0)
            begin
                coef_ch.ready = 1'b0;
                stall_left--;
            end
            else
                coef_ch.ready = 1'b1;
        end
    end

    task automatic note_bad(input string what, input dcd_pkg::coef_t want,
                            input dcd_pkg::coef_t got);
        n_bad++;
        if (n_bad <= 10)
        begin
            $display("%0t %s: expected idx=%0d val=%0d end=%b fault=%b last=%b",
                     $time, what, want.coef_index, want.coef_value, want.block_end,
                     want.fault, want.last_of_run);
            $display("%0t %s: got      idx=%0d val=%0d end=%b fault=%b last=%b",
                     $time, what, got.coef_index, got.coef_value, got.block_end,
                     got.fault, got.last_of_run);
        end
    endtask

    always @(posedge clk)
    begin
        dcd_pkg::coef_t want;
        dcd_pkg::coef_t got;
        if (rst_n && coef_ch.valid && coef_ch.ready)
        begin
            got = coef_ch.data;
            n_results++;
            stall_left = $urandom_range(0, stall_max);
            if (got.block_end)
                n_blocks++;
            if (got.fault)
                n_faults++;
            if (coef_q.size() == 0)
                note_bad("unexpected coefficient", '0, got);
            else
            begin
                want = coef_q.pop_front();
                if (got.coef_index !== want.coef_index || got.coef_value !== want.coef_value
                    || got.block_end !== want.block_end || got.fault !== want.fault
                    || got.last_of_run !== want.last_of_run)
                    note_bad("mismatch", want, got);
            end
        end
    end

    initial
    begin
        #15_000_000;
        $display("timeout with %0d coefficients outstanding", coef_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_quant_table();
        test_code_kinds();
        test_faults();
        test_backpressure();
        test_random_streams();

        wait_drained();
        repeat (20) @(posedge clk);
        $display("Sent %0d items; checked %0d coefficients, %0d complete blocks, %0d faults",
                 n_items, n_results, n_blocks, n_faults);
        $display("Mismatched or unexpected coefficients: %0d", n_bad);
        if (n_bad == 0 && coef_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
